[hw/rtl/htlp_pkg.sv]
package htlp_pkg;
  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [7:0] CTRL_EMPTY   = 8'h80;
  localparam logic [7:0] CTRL_DELETED = 8'hFE;
  localparam logic [7:0] BYTE_MASK    = 8'hFF;

  localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME  = 64'h00000100000001B3;
endpackage

[hw/rtl/htlp_if.sv]
interface htlp_if #(
  parameter int unsigned PW = 8
);
  logic          valid;
  logic          ready;
  logic [PW-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/hash_table_linear_probe_top.sv]
// A request is hashed, then each probed slot is read and evaluated, an insert then writes
// its slot, and the result is registered for output.
// Only one request is handled at a time, and a new one is taken only once the last result
// has been taken. Hashing and the one-read-port memories set the rate. After reset a
// clearing pass writes every control byte to empty, during which no request is taken.
module hash_table_linear_probe_top
  import htlp_pkg::*;
#(
  parameter int unsigned SLOTS      = 1024,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned KEY_BITS   = 64
) (
  input  logic clk,
  input  logic rst_n,
  htlp_if.sink   in_ch,
  htlp_if.source out_ch
);
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_FREE  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [1:0] op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [AW-1:0] pos_r, pos_nxt, free_r, free_nxt;
  logic [CW-1:0] n_r, n_nxt, live_r, live_nxt, used_r, used_nxt;
  logic [6:0] tag_r, tag_nxt;
  logic       free_ok_r, free_ok_nxt, o_valid_r, o_valid_nxt;
  logic       free_emp_r, free_emp_nxt;
  logic [1:0] o_status_r, o_status_nxt;
  logic [9:0] o_slot_r, o_slot_nxt;
  logic [31:0] o_val_r, o_val_nxt;
  logic       hash_done;
  logic [63:0] hash;
  logic [AW-1:0] raddr, waddr;
  logic [7:0] c_rd, c_wd;
  logic [KEY_BITS-1:0] k_rd;
  logic [VALUE_BITS-1:0] v_rd;
  logic c_we, kv_we;
  logic [1:0] in_op;
  logic [KEY_BITS-1:0] in_key;
  logic [VALUE_BITS-1:0] in_value;

  assign in_op    = in_ch.payload[1:0];
  assign in_key   = in_ch.payload[2 +: KEY_BITS];
  assign in_value = in_ch.payload[2 + KEY_BITS +: VALUE_BITS];

  htlp_hash #(.KEY_BITS(KEY_BITS)) u_hash (
    .clk, .rst_n, .start(st_r == S_IDLE && in_ch.valid && in_ch.ready),
    .key(in_key), .done(hash_done), .hash(hash)
  );

  htlp_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_ctrl (
    .clk, .we(c_we), .waddr(waddr), .wdata(c_wd), .raddr(raddr), .rdata(c_rd));
  htlp_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_keys (
    .clk, .we(kv_we), .waddr(waddr), .wdata(key_r), .raddr(raddr), .rdata(k_rd));
  htlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_vals (
    .clk, .we(kv_we), .waddr(waddr), .wdata(val_r), .raddr(raddr), .rdata(v_rd));

  assign in_ch.ready = (st_r == S_IDLE) && !o_valid_r;
  assign raddr = pos_r;

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; key_nxt = key_r; val_nxt = val_r;
    pos_nxt = pos_r; free_nxt = free_r; n_nxt = n_r;
    live_nxt = live_r; used_nxt = used_r; tag_nxt = tag_r; free_ok_nxt = free_ok_r;
    free_emp_nxt = free_emp_r;
    o_valid_nxt = o_valid_r; o_status_nxt = o_status_r; o_slot_nxt = o_slot_r;
    o_val_nxt = o_val_r;
    c_we = 1'b0; kv_we = 1'b0; waddr = pos_r; c_wd = CTRL_EMPTY;
    if (o_valid_r && out_ch.ready) o_valid_nxt = 1'b0;
    case (st_r)
      S_CLEAR: begin
        c_we = 1'b1;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == LAST) begin
          st_nxt = S_IDLE; pos_nxt = '0;
        end
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          op_nxt = in_op; key_nxt = in_key; val_nxt = in_value;
          st_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          tag_nxt = hash[6:0];
          pos_nxt = AW'(hash >> 7);
          n_nxt = '0; free_ok_nxt = 1'b0;
          if (op_r == OP_FIND || op_r == OP_INSERT || op_r == OP_DELETE) begin
            st_nxt = S_READ;
          end else begin
            o_status_nxt = ST_NOTFOUND; o_slot_nxt = '0; o_val_nxt = '0;
            st_nxt = S_OUT;
          end
        end
      end
      S_READ: st_nxt = S_EVAL;
      S_EVAL: begin
        if (op_r == OP_INSERT && c_rd[7] && !free_ok_r) begin
          free_ok_nxt = 1'b1; free_nxt = pos_r;
          free_emp_nxt = (c_rd == CTRL_EMPTY);
        end
        if (c_rd == {1'b0, tag_r} && k_rd == key_r) begin
          o_status_nxt = (op_r == OP_DELETE) ? ST_DONE : ST_FOUND;
          o_slot_nxt = 10'(pos_r); o_val_nxt = 32'(v_rd);
          if (op_r == OP_DELETE) begin
            c_we = 1'b1; c_wd = CTRL_DELETED;
            if (live_r != '0) live_nxt = live_r - 1'b1;
          end
          st_nxt = S_OUT;
        end else if (c_rd == CTRL_EMPTY || n_r == CW'(SLOTS - 1)) begin
          if (op_r == OP_INSERT) begin
            // first free slot seen, else nothing free on this lap
            if (free_ok_r || c_rd[7]) begin
              waddr = free_ok_r ? free_r : pos_r;
              pos_nxt = free_ok_r ? free_r : pos_r;
              st_nxt = S_FREE;
              if (!free_ok_r) free_nxt = pos_r;
              if (free_ok_r) begin
                st_nxt = S_FREE; pos_nxt = free_r;
              end
            end else begin
              o_status_nxt = ST_FULL; o_slot_nxt = '0; o_val_nxt = '0;
              st_nxt = S_OUT;
            end
          end else begin
            o_status_nxt = ST_NOTFOUND; o_slot_nxt = '0; o_val_nxt = '0;
            st_nxt = S_OUT;
          end
        end else begin
          pos_nxt = (pos_r == LAST) ? '0 : pos_r + 1'b1;
          n_nxt = n_r + 1'b1;
          st_nxt = S_READ;
        end
      end
      S_FREE: begin
        // a slot that was empty adds to the used count
        c_we = 1'b1; kv_we = 1'b1; c_wd = {1'b0, tag_r};
        if (free_emp_r) used_nxt = used_r + 1'b1;
        live_nxt = live_r + 1'b1;
        o_status_nxt = ST_DONE; o_slot_nxt = 10'(pos_r); o_val_nxt = 32'(val_r);
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!o_valid_r) begin
          o_valid_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; pos_r <= '0; live_r <= '0; used_r <= '0; o_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pos_r <= pos_nxt; live_r <= live_nxt; used_r <= used_nxt;
      o_valid_r <= o_valid_nxt;
    end
    op_r <= op_nxt; key_r <= key_nxt; val_r <= val_nxt;
    free_r <= free_nxt; n_r <= n_nxt; tag_r <= tag_nxt; free_ok_r <= free_ok_nxt;
    free_emp_r <= free_emp_nxt;
    o_status_r <= o_status_nxt; o_slot_r <= o_slot_nxt; o_val_r <= o_val_nxt;
  end

  assign out_ch.valid = o_valid_r;
  assign out_ch.payload = {11'(live_r), o_val_r, o_slot_r, o_status_r};
endmodule

[hw/rtl/htlp_ram.sv]
module htlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/htlp_hash.sv]
module htlp_hash
  import htlp_pkg::*;
#(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [KEY_BITS-1:0] key,
  output logic                done,
  output logic [63:0]         hash
);
  // one key byte at a time, and a new key is not taken while busy; each byte is XORed in, then
  // multiplied by the prime as two 32-bit halves times 0x1B3 plus the shifted term
  logic [63:0] h_r, h_nxt, k_r, k_nxt, x_r, x_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        ph_r, ph_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [63:0] lo_prod, hi_prod;
  logic [63:0] kx;

  assign kx = 64'(key);
  // prime = 0x100_000001B3: h*p = h*0x1B3 + (h<<40)
  assign lo_prod = 64'(x_r[31:0]) * 64'h1B3;
  assign hi_prod = 64'(x_r[63:32]) * 64'h1B3;

  always_comb begin
    h_nxt = h_r; k_nxt = k_r; x_nxt = x_r; cnt_nxt = cnt_r;
    ph_nxt = ph_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start && !busy_r) begin
      busy_nxt = 1'b1; k_nxt = kx; cnt_nxt = '0; ph_nxt = 1'b0;
      h_nxt = FNV_OFFSET;
    end else if (busy_r) begin
      if (!ph_r) begin
        x_nxt = h_r ^ {56'd0, k_r[7:0] & BYTE_MASK};
        ph_nxt = 1'b1;
      end else begin
        h_nxt = lo_prod + {hi_prod[31:0], 32'd0} + {x_r[23:0], 40'd0};
        k_nxt = k_r >> 8;
        ph_nxt = 1'b0;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd7) begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; ph_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; ph_r <= ph_nxt; cnt_r <= cnt_nxt;
    end
    h_r <= h_nxt; k_r <= k_nxt; x_r <= x_nxt;
  end

  assign done = done_r;
  assign hash = h_r;
endmodule

[hw/rtl/htlp_checker.sv]
module htlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [54:0] out_payload
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload)) else $error("out held");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accept while busy");
  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload[1:0] == 2'd3 |-> out_payload[11:2] == 10'd0)
    else $error("full with slot");
  a_no_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready with pending result");
endmodule

bind hash_table_linear_probe_top htlp_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload[54:0]));
